// File: hdl/bb3_pkg.sv
package bb3_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAST,
        S_DSTART,
        S_DIV,
        S_PUSH
    } t_state;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;
    localparam int NUM_W   = 13;
    localparam int DEN_W   = 5;
    localparam int CFG_W   = 16;
    localparam int ROW_W   = 16;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] cnt;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_div_rsp;

endpackage

// File: hdl/bb3_if.sv
interface bb3_pix_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output opcode, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input opcode, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

interface bb3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_last, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_last, output ready);
endinterface

// File: hdl/box_blur_3x3_edge_aware.sv
// Channel   Dir  Beat contents
// i_pix     in   opcode, in_red, in_green, in_blue
// o_res     out  out_red, out_green, out_blue, frame_last
// i_cfg_*   in   write enable, register index, write data
//
// A pixel that releases no output is accepted and the block stays ready. A pixel
// or flush that releases an output is accepted, then come nine line store reads
// on the single read port, the closing of the sums, eight divider steps, the
// divider's report and the load of the output register.
// The result sits in an output register, so a new beat is taken while it waits.
// Reset is synchronous; the line store is not cleared.
module box_blur_3x3_edge_aware
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bb3_pix_if.sink          i_pix,
    bb3_res_if.source        o_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int DEPTH = 2 * MAX_WIDTH + 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int PW    = $clog2(MAX_WIDTH + 3);
    localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a,
                                              input logic [AW:0] b);
        logic [AW+1:0] s;
        s = (AW+2)'(a) + (AW+2)'(b);
        if (s >= (AW+2)'(DEPTH)) begin
            s = s - (AW+2)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    t_state r_state, n_state;

    logic [WW-1:0]    r_w;
    logic [ROW_W-1:0] r_h;
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COLW-1:0]  r_in_col, n_in_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [COLW-1:0]  r_out_col, n_out_col;
    logic [PW-1:0]    r_pend, n_pend;
    logic             r_drain, n_drain;
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [ROW_W-1:0] r_e_row;
    logic [COLW-1:0]  r_e_col;
    logic             r_e_last;
    logic [AW-1:0]    r_addr;
    logic [1:0]       r_r, r_c;
    logic             r_take, r_inb;
    logic [SUM_W-1:0] r_sr, r_sg, r_sb;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovalid;
    logic [CH_W-1:0]  r_ored, r_ogreen, r_oblue;
    logic             r_olast;

    logic             acc, emit, last, issue, push, in_ready;
    logic [ROW_W-1:0] b_row;
    logic [COLW-1:0]  b_col;
    logic [AW-1:0]    b_rd;
    logic [PW-1:0]    b_pend;
    logic [AW:0]      start_off, step_row;
    logic [WW-1:0]    w_eff;
    logic [ROW_W:0]   rt;
    logic [WW:0]      ct;
    logic             inb;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    assign acc = i_pix.valid && in_ready;

    // Configuration.
    always_comb begin
        if (i_cfg_data[11:0] == '0) begin
            w_eff = WW'(1);
        end else if (14'(i_cfg_data[11:0]) > 14'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_cfg_data[11:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WW'(W_RST);
            r_h <= ROW_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_w <= w_eff;
                REG_FRAME_HEIGHT: r_h <= (i_cfg_data == '0) ? ROW_W'(1) : i_cfg_data;
                default:          r_w <= r_w;
            endcase
        end
    end

    // Bookkeeping for an accepted beat.
    always_comb begin
        b_row  = r_out_row;
        b_col  = r_out_col;
        b_rd   = r_rd;
        b_pend = r_pend;
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_drain   = r_drain;
        emit      = 1'b0;
        last      = 1'b0;
        if (i_pix.opcode == OP_PIXEL) begin
            if (r_drain) begin
                b_row  = '0;
                b_col  = '0;
                b_rd   = r_wr;
                b_pend = '0;
            end
            b_pend = b_pend + PW'(1);
            emit = (b_pend > PW'(r_w) + PW'(1));
            last = ((ROW_W+1)'(r_in_row) + 1'b1 >= (ROW_W+1)'(r_h))
                && ((WW+1)'(r_in_col) + 1'b1 >= (WW+1)'(r_w));
            if ((WW+1)'(r_in_col) + 1'b1 >= (WW+1)'(r_w)) begin
                n_in_col = '0;
                n_in_row = ((ROW_W+1)'(r_in_row) + 1'b1 >= (ROW_W+1)'(r_h))
                         ? '0 : r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end else begin
            emit = r_drain && (r_pend != '0);
        end
        n_out_row = b_row;
        n_out_col = b_col;
        n_rd      = b_rd;
        n_pend    = b_pend;
        if (emit) begin
            if ((WW+1)'(b_col) + 1'b1 >= (WW+1)'(r_w)) begin
                n_out_col = '0;
                n_out_row = ((ROW_W+1)'(b_row) + 1'b1 >= (ROW_W+1)'(r_h))
                          ? '0 : b_row + 1'b1;
            end else begin
                n_out_col = b_col + 1'b1;
            end
            n_rd   = (b_rd == AW'(DEPTH - 1)) ? '0 : b_rd + 1'b1;
            n_pend = b_pend - PW'(1);
        end
        if (i_pix.opcode == OP_PIXEL) begin
            n_drain = last && (n_pend != '0);
        end else begin
            n_drain = emit && (n_pend != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pend    <= '0;
            r_drain   <= 1'b0;
            r_wr      <= '0;
            r_rd      <= '0;
        end else if (acc) begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_pend    <= n_pend;
            r_drain   <= n_drain;
            r_rd      <= n_rd;
            if (i_pix.opcode == OP_PIXEL) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
        end
    end

    // Line store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (acc && i_pix.opcode == OP_PIXEL) begin
            mem[r_wr] <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        end
        r_rdata <= mem[r_addr];
    end

    // Window walk: up-left neighbor first, then raster order over the 3x3.
    assign start_off = (AW+1)'(DEPTH - 1) - (AW+1)'(r_w);
    assign step_row  = ((AW+1)'(r_w) + (AW+1)'(DEPTH - 2) >= (AW+1)'(DEPTH))
                     ? (AW+1)'(r_w) - 2'd2 : (AW+1)'(r_w) + (AW+1)'(DEPTH - 2);
    assign rt  = (ROW_W+1)'(r_e_row) + (ROW_W+1)'(r_r);
    assign ct  = (WW+1)'(r_e_col) + (WW+1)'(r_c);
    assign inb = (rt != '0) && (rt <= (ROW_W+1)'(r_h))
              && (ct != '0) && (ct <= (WW+1)'(r_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_take <= 1'b0;
        end else begin
            r_take <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_e_row  <= b_row;
            r_e_col  <= b_col;
            r_e_last <= ((ROW_W+1)'(b_row) + 1'b1 >= (ROW_W+1)'(r_h))
                     && ((WW+1)'(b_col) + 1'b1 >= (WW+1)'(r_w));
            r_addr   <= mod_add(b_rd, start_off);
            r_r      <= '0;
            r_c      <= '0;
            r_sr     <= '0;
            r_sg     <= '0;
            r_sb     <= '0;
            r_cnt    <= '0;
        end else begin
            if (issue) begin
                r_inb  <= inb;
                r_addr <= mod_add(r_addr, (r_c == 2'd2) ? step_row : (AW+1)'(1));
                if (r_c == 2'd2) begin
                    r_c <= '0;
                    r_r <= r_r + 2'd1;
                end else begin
                    r_c <= r_c + 2'd1;
                end
            end
            if (r_take && r_inb) begin
                r_sr  <= r_sr + SUM_W'(r_rdata[23:16]);
                r_sg  <= r_sg + SUM_W'(r_rdata[15:8]);
                r_sb  <= r_sb + SUM_W'(r_rdata[7:0]);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.cnt   = r_cnt;

    bb3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_sum_r (r_sr),
        .i_sum_g (r_sg),
        .i_sum_b (r_sb),
        .o_rsp   (div_rsp)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (acc && emit) n_state = S_READ;
            S_READ:   if (r_r == 2'd2 && r_c == 2'd2) n_state = S_LAST;
            S_LAST:   n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (div_rsp.done) n_state = S_PUSH;
            S_PUSH:   if (!r_ovalid || o_res.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        push     = 1'b0;
        unique case (r_state)
            S_IDLE:  in_ready = 1'b1;
            S_READ:  issue    = 1'b1;
            S_PUSH:  push     = !r_ovalid || o_res.ready;
            default: in_ready = 1'b0;
        endcase
    end

    assign i_pix.ready = in_ready;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ored   <= div_rsp.red;
            r_ogreen <= div_rsp.green;
            r_oblue  <= div_rsp.blue;
            r_olast  <= r_e_last;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.out_red    = r_ored;
    assign o_res.out_green  = r_ogreen;
    assign o_res.out_blue   = r_oblue;
    assign o_res.frame_last = r_olast;

endmodule

// File: hdl/bb3_div.sv
module bb3_div
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    input  logic [SUM_W-1:0] i_sum_r,
    input  logic [SUM_W-1:0] i_sum_g,
    input  logic [SUM_W-1:0] i_sum_b,
    output t_div_rsp         o_rsp
);

    // Rounded mean as (2*sum + cnt) / (2*cnt). The quotient always fits in
    // eight bits, so one shifted compare and subtract per bit suffices.
    logic [NUM_W-1:0] r_rem [3];
    logic [CH_W-1:0]  r_q [3];
    logic [DEN_W-1:0] r_den;
    logic [2:0]       r_bit;
    logic             r_busy;
    logic             r_done;
    logic             r_zero;
    logic [NUM_W-1:0] dsh;
    logic [SUM_W-1:0] sums [3];

    assign sums[0] = i_sum_r;
    assign sums[1] = i_sum_g;
    assign sums[2] = i_sum_b;
    assign dsh = NUM_W'(r_den) << r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 3'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= {i_req.cnt, 1'b0};
            r_zero <= (i_req.cnt == '0);
            r_bit  <= 3'd7;
            for (int ch = 0; ch < 3; ch++) begin
                r_rem[ch] <= {sums[ch], 1'b0} + NUM_W'(i_req.cnt);
                r_q[ch]   <= '0;
            end
        end else if (r_busy) begin
            r_bit <= r_bit - 3'd1;
            for (int ch = 0; ch < 3; ch++) begin
                if (r_rem[ch] >= dsh) begin
                    r_rem[ch]      <= r_rem[ch] - dsh;
                    r_q[ch][r_bit] <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.red   = r_zero ? '0 : r_q[0];
    assign o_rsp.green = r_zero ? '0 : r_q[1];
    assign o_rsp.blue  = r_zero ? '0 : r_q[2];

endmodule

// File: hdl/bb3_chk.sv
module bb3_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);

    // An output beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat withdrawn before it was taken");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_last))
        else $error("frame_last changed while stalled");

    // Results are only produced while the input side is closed.
    a_rose_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("output appeared without a compute phase");

    // The input closes only after it took a beat.
    a_fell_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))
        else $error("input closed without an accepted beat");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind box_blur_3x3_edge_aware bb3_chk u_bb3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_last  (o_res.frame_last)
);

// File: bench/box_blur_3x3_edge_aware_checker.sv
module box_blur_3x3_edge_aware_checker
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bb3_pix_if               pix,
    bb3_res_if               res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 2 * MAX_WIDTH + 4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_px;

    t_blur_px    blur_q[$];
    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [23:0] px_store [DEPTH];
    int unsigned in_row, in_col, out_row, out_col, held, rd_ptr, wr_ptr;
    bit          draining;
    int          errors;

    function automatic int unsigned cols();
        int unsigned w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned rows();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function automatic logic [7:0] rounded_mean(int unsigned sum, int unsigned cnt);
        if (cnt == 0) return 8'd0;
        return 8'((2 * sum + cnt) / (2 * cnt));
    endfunction

    // Averages the in-image neighbors of the next output pixel and advances it.
    function automatic void release_pixel();
        int unsigned w, h, sr, sg, sb, cnt;
        int          rr, cc, a;
        logic [23:0] p;
        t_blur_px    e;
        w = cols();
        h = rows();
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = int'(out_row) + dr;
                cc = int'(out_col) + dc;
                if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w)) begin
                    a = (int'(rd_ptr) + dr * int'(w) + dc + 2 * DEPTH) % DEPTH;
                    p = px_store[a];
                    sr += p[23:16];
                    sg += p[15:8];
                    sb += p[7:0];
                    cnt++;
                end
            end
        end
        e.red   = rounded_mean(sr, cnt);
        e.green = rounded_mean(sg, cnt);
        e.blue  = rounded_mean(sb, cnt);
        e.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
        blur_q.push_back(e);
        if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
        end else begin
            out_col++;
        end
        rd_ptr = (rd_ptr + 1) % DEPTH;
        held--;
    endfunction

    function automatic void take_beat(logic op, logic [23:0] rgb);
        int unsigned w, h;
        bit          last;
        w = cols();
        h = rows();
        if (op == OP_FLUSH) begin
            if (draining && held > 0) begin
                release_pixel();
                if (held == 0) draining = 0;
            end else begin
                draining = 0;
            end
            return;
        end
        if (draining) begin
            // A new frame abandons what was left of the old one.
            draining = 0;
            held = 0;
            out_row = 0;
            out_col = 0;
            rd_ptr = wr_ptr;
        end
        px_store[wr_ptr] = rgb;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        held++;
        last = (in_row + 1 >= h) && (in_col + 1 >= w);
        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
        end else begin
            in_col++;
        end
        if (held > w + 1) release_pixel();
        if (last) draining = (held > 0);
    endfunction

    always @(posedge i_clk) begin
        t_blur_px got, want;
        if (!i_rst_n) begin
            width_reg = 12'd640;
            height_reg = 16'd480;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            held = 0; rd_ptr = 0; wr_ptr = 0; draining = 0;
            blur_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) width_reg = i_cfg_data[11:0];
                else height_reg = i_cfg_data;
            end
            if (res.valid && res.ready) begin
                got = {res.out_red, res.out_green, res.out_blue, res.frame_last};
                if (blur_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected output beat r=%0d g=%0d b=%0d last=%0b",
                                 got.red, got.green, got.blue, got.last);
                end else begin
                    want = blur_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                                     want.red, want.green, want.blue, want.last,
                                     got.red, got.green, got.blue, got.last);
                    end
                end
            end
            if (pix.valid && pix.ready)
                take_beat(pix.opcode, {pix.in_red, pix.in_green, pix.in_blue});
        end
        o_waiting <= blur_q.size();
    end

    initial begin
        errors = 0;
        o_waiting = 0;
        foreach (px_store[i]) px_store[i] = '0;
    end

    assign o_errors = errors;
endmodule

// File: bench/box_blur_3x3_edge_aware_tb.sv
module box_blur_3x3_edge_aware_tb;
    import bb3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               errors, waiting, beats_sent;
    bit               quiet, long_hold, did_hold;

    bb3_pix_if pix();
    bb3_res_if res();

    box_blur_3x3_edge_aware dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix), .o_res(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    box_blur_3x3_edge_aware_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .pix(pix), .res(res),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_waiting(waiting)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("box_blur_3x3_edge_aware regression: fail");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold on request.
    initial begin
        int n;
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                res.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
                res.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 7);
                res.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.opcode <= op;
        pix.in_red <= r;
        pix.in_green <= g;
        pix.in_blue <= b;
        do @(posedge i_clk); while (!pix.ready);
        beats_sent++;
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        while (waiting != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_frame(logic [15:0] w, logic [15:0] h);
        settle();
        cfg_we <= 1'b1;
        cfg_idx <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        cfg_idx <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Sends one frame; pattern 1 alternates full-scale yellow and blue.
    // With cut set, the drain stops early and the next frame abandons it.
    task automatic frame(int w, int h, bit pattern, bit cut);
        int n, left, flushes;
        logic [7:0] v;
        if (w < 1) w = 1;
        if (w > 2048) w = 2048;
        if (h < 1) h = 1;
        n = w * h;
        for (int i = 0; i < n; i++) begin
            if (!pattern && $urandom_range(0, 40) == 0)
                send_beat(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
            v = ((i + i / w) % 2) ? 8'hFF : 8'h00;
            if (pattern) send_beat(OP_PIXEL, v, v, ~v);
            else send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        end
        left = (n < w + 1) ? n : w + 1;
        flushes = cut ? $urandom_range(0, left - 1) : left + $urandom_range(0, 2);
        repeat (flushes) send_beat(OP_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        int w, h, k;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_FRAME_WIDTH;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.opcode = OP_PIXEL;
        pix.in_red = '0;
        pix.in_green = '0;
        pix.in_blue = '0;
        quiet = 0;
        long_hold = 0;
        did_hold = 0;
        beats_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A flush with nothing to drain releases nothing.
        send_beat(OP_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        set_frame(16'd1, 16'd1);
        frame(1, 1, 1, 0);
        set_frame(16'd0, 16'd0);
        frame(1, 1, 0, 0);
        set_frame(16'd3, 16'd3);
        frame(3, 3, 1, 0);

        while (beats_sent < 1500) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
            h = $urandom_range(0, 6);
            set_frame(16'(w), 16'(h));
            k = $urandom_range(1, 3);
            for (int f = 0; f < k; f++) frame(w, h, 0, f < k - 1 && $urandom_range(0, 1));
            if (beats_sent > 600 && !did_hold) begin
                set_frame(16'd8, 16'd8);
                did_hold = 1;
                long_hold = 1;
                frame(8, 8, 0, 0);
            end
            if (beats_sent > 1300) quiet = 1;
        end

        // Tall frame, only its top is streamed at the very end.
        set_frame(16'd1, 16'hFFFF);
        repeat (20) send_beat(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        settle();
        repeat (50) @(posedge i_clk);

        if (errors == 0 && waiting == 0) begin
            $display("box_blur_3x3_edge_aware regression: pass");
        end else begin
            $display("box_blur_3x3_edge_aware regression: fail");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/bb3_pkg.sv
hdl/bb3_if.sv
hdl/bb3_div.sv
hdl/box_blur_3x3_edge_aware.sv
hdl/bb3_chk.sv
bench/box_blur_3x3_edge_aware_checker.sv
bench/box_blur_3x3_edge_aware_tb.sv
